[rtl/core/pdbb_pkg.sv]
// Shared types and constants for the page display bitmap blit.
package pdbb_pkg;

	localparam logic [7:0] COL_CMD  = 8'b0100_0000;
	localparam logic [7:0] PAGE_CMD = 8'b1011_1000;
	localparam logic [7:0] COL_MASK = 8'b0011_1111;
	localparam logic [7:0] PAGE_MASK = 8'b0000_0111;

	localparam logic [1:0] CFG_X_ORIGIN      = 2'd0;
	localparam logic [1:0] CFG_Y_ORIGIN      = 2'd1;
	localparam logic [1:0] CFG_IMAGE_COLUMNS = 2'd2;
	localparam logic [1:0] CFG_IMAGE_PAGES   = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [6:0] x_origin;
		logic [5:0] y_origin;
		logic [7:0] image_columns;
		logic [3:0] image_pages;
	} cfg_t;

	// One classified byte, ready to be turned into bus writes.
	typedef struct packed {
		logic       cs;
		logic [5:0] col;
		logic [2:0] page;
		logic [7:0] data;
		logic [7:0] spill;
		logic       two;
	} job_t;

endpackage

[rtl/core/pdbb_front.sv]
// Front end: counters, line store, shift and merge of each image byte.
module pdbb_front import pdbb_pkg::*; #(
	parameter int MAX_COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_byte,
	input  logic       first_of_image,
	output logic       job_valid,
	output job_t       job,
	input  logic       queue_full
);

	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam logic [8:0] MAX_COLS9 = 9'(MAX_COLUMNS);

	logic [CW-1:0]  col_q;
	logic [2:0]     row_q;
	logic [7:0]     store [MAX_COLUMNS];

	logic           valid_s1;
	logic [7:0]     pixel_s1;
	logic [7:0]     prev_s1;
	logic [2:0]     shift_s1;
	logic           merge_s1;
	logic           cs_s1;
	logic [5:0]     col_s1;
	logic [2:0]     page_s1;

	logic [8:0]     cols9;
	logic [CNW-1:0] cols_eff;
	logic [3:0]     pages_eff;
	logic [CW-1:0]  col_base;
	logic [CW-1:0]  col_cur;
	logic [2:0]     row_base;
	logic [2:0]     row_cur;
	logic [CNW-1:0] col_inc;
	logic [3:0]     row_inc;
	logic [7:0]     xloc;
	logic           accept;
	logic           push;
	logic [3:0]     back_shift;

	always_comb begin
		if (cfg.image_columns == 8'd0)
			cols9 = 9'd1;
		else if ({1'b0, cfg.image_columns} > MAX_COLS9)
			cols9 = MAX_COLS9;
		else
			cols9 = {1'b0, cfg.image_columns};
		cols_eff = cols9[CNW-1:0];

		if (cfg.image_pages == 4'd0)
			pages_eff = 4'd1;
		else if (cfg.image_pages > 4'd8)
			pages_eff = 4'd8;
		else
			pages_eff = cfg.image_pages;

		col_base = first_of_image ? '0 : col_q;
		row_base = first_of_image ? 3'd0 : row_q;
		col_cur  = (CNW'(col_base) >= cols_eff) ? '0 : col_base;
		row_cur  = ({1'b0, row_base} >= pages_eff) ? 3'd0 : row_base;
		col_inc  = CNW'(col_cur) + CNW'(1);
		row_inc  = {1'b0, row_cur} + 4'd1;
		xloc     = 8'(col_cur) + {1'b0, cfg.x_origin};
	end

	assign push     = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || !queue_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= 3'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (col_inc >= cols_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= pages_eff) ? 3'd0 : row_inc[2:0];
				end else begin
					col_q <= col_inc[CW-1:0];
					row_q <= row_cur;
				end
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The store is read before it is written at the same edge, so the merge sees
	// the byte of the page row above, never the byte being stored now.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1         <= store[col_cur];
			store[col_cur]  <= pixel_byte;
			pixel_s1        <= pixel_byte;
			shift_s1        <= cfg.y_origin[2:0];
			merge_s1        <= (cfg.y_origin[2:0] != 3'd0) && (row_cur != 3'd0);
			cs_s1           <= (xloc[7:6] != 2'b00);
			col_s1          <= xloc[5:0];
			page_s1         <= cfg.y_origin[5:3] + row_cur;
		end
	end

	assign back_shift = 4'd8 - {1'b0, shift_s1};

	always_comb begin
		job.cs    = cs_s1;
		job.col   = col_s1;
		job.page  = page_s1;
		job.data  = 8'(pixel_s1 << shift_s1) | (merge_s1 ? (prev_s1 >> back_shift) : 8'd0);
		job.spill = pixel_s1 >> back_shift;
		job.two   = (shift_s1 != 3'd0);
	end

	assign job_valid = valid_s1;

endmodule

[rtl/core/pdbb_queue.sv]
// Short job queue between the front end and the bus write sequencer.
module pdbb_queue import pdbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	job_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full       = (count_q == NW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

[rtl/core/pdbb_back.sv]
// Back end: steps each job through its bus writes into the output register.
module pdbb_back import pdbb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       chip_select,
	output logic       register_select,
	output logic [7:0] bus_byte,
	output logic       last_write
);

	localparam logic [2:0] STEP_COL   = 3'd0;
	localparam logic [2:0] STEP_PAGE  = 3'd1;
	localparam logic [2:0] STEP_DATA  = 3'd2;
	localparam logic [2:0] STEP_COL2  = 3'd3;
	localparam logic [2:0] STEP_PAGE2 = 3'd4;
	localparam logic [2:0] STEP_SPILL = 3'd5;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic       cs_q;
	logic       rs_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       rs_d;
	logic [7:0] byte_d;
	logic       last_d;
	logic [2:0] page_next;

	assign page_next = head.page + 3'd1;

	always_comb begin
		rs_d   = 1'b0;
		last_d = 1'b0;
		case (step_q)
			STEP_COL, STEP_COL2: begin
				byte_d = COL_CMD | ({2'b00, head.col} & COL_MASK);
			end
			STEP_PAGE: begin
				byte_d = PAGE_CMD | ({5'd0, head.page} & PAGE_MASK);
			end
			STEP_PAGE2: begin
				byte_d = PAGE_CMD | ({5'd0, page_next} & PAGE_MASK);
			end
			STEP_DATA: begin
				rs_d   = 1'b1;
				byte_d = head.data;
				last_d = !head.two;
			end
			STEP_SPILL: begin
				rs_d   = 1'b1;
				byte_d = head.spill;
				last_d = 1'b1;
			end
			default: begin
				byte_d = head.data;
				last_d = 1'b1;
			end
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_COL;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_d ? STEP_COL : step_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cs_q   <= head.cs;
			rs_q   <= rs_d;
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign chip_select     = cs_q;
	assign register_select = rs_q;
	assign bus_byte        = byte_q;
	assign last_write      = last_q;

endmodule

[rtl/core/page_display_bitmap_blit.sv]
// Top level of the page display bitmap blit with its configuration registers.
//
// Image bytes arrive on the in channel (pixel_byte, first_of_image) in raster
// order, one page row of image_columns bytes after another. Each byte leaves as
// bus words on the out channel: column address, page address and data, then,
// when y_origin is not page aligned, a second address pair and the spill byte.
// last_write marks the final word of each byte. Configuration words go in on
// the cfg channel, which is always ready; write it only while the block is idle.
// An accepted byte passes the front end register and the queue before its first
// word is presented. The sequencer puts out one word per cycle unless the
// receiver stalls; a byte has three words with an aligned y_origin and six
// otherwise. The front end and two-entry queue take bytes while it works.
// When the receiver stalls, the output word holds, the queue fills and then
// in_ready drops.
// Reset clears the column and row counters and sets the registers to their
// defaults; the line store needs no clearing, as the first page row of an
// image never merges with it.
module page_display_bitmap_blit import pdbb_pkg::*; #(
	parameter int MAX_COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_byte,
	input  logic       first_of_image,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       chip_select,
	output logic       register_select,
	output logic [7:0] bus_byte,
	output logic       last_write
);

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic q_full;
	logic q_pop;
	logic q_head_valid;
	job_t q_head;
	logic q_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin      <= 7'd0;
			cfg_q.y_origin      <= 6'd0;
			cfg_q.image_columns <= 8'd1;
			cfg_q.image_pages   <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_X_ORIGIN:      cfg_q.x_origin      <= cfg_data[6:0];
				CFG_Y_ORIGIN:      cfg_q.y_origin      <= cfg_data[5:0];
				CFG_IMAGE_COLUMNS: cfg_q.image_columns <= cfg_data;
				CFG_IMAGE_PAGES:   cfg_q.image_pages   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	pdbb_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_byte(pixel_byte),
		.first_of_image(first_of_image),
		.job_valid(job_valid),
		.job(job),
		.queue_full(q_full)
	);

	assign q_push = job_valid && !q_full;

	pdbb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(job),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_head_valid),
		.head(q_head)
	);

	pdbb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(q_head_valid),
		.head(q_head),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chip_select(chip_select),
		.register_select(register_select),
		.bus_byte(bus_byte),
		.last_write(last_write)
	);

	// Every byte ends on a data word.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_write |-> register_select)
		else $error("last word of a byte is not a data word");

	// Instruction words are only column or page address commands.
	a_cmd_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !register_select |->
			(bus_byte[7:6] == 2'b01) || (bus_byte[7:3] == 5'b10111))
		else $error("instruction word is neither a column nor a page command");

	// A held byte in the front end with a full queue must stop the input.
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && q_full |-> !in_ready)
		else $error("input taken while the front end is blocked");

	// A word taken with more to come leaves a word pending in the same job.
	a_job_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write |-> q_head_valid)
		else $error("job left the queue before its last word");

endmodule
